### rtl/core/saes_pkg.sv
// Package: shared types, S-box tables and GF(16) helpers for S-AES decryption.
`timescale 1ns / 1ps
`default_nettype none

package saes_pkg;

  localparam int unsigned BLOCK_W  = 16;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] RCON1 = 8'h80;
  localparam logic [BYTE_W-1:0] RCON2 = 8'h30;

  typedef logic [NIBBLE_W-1:0] nibble_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [BLOCK_W-1:0]  block_t;

  typedef struct packed {
    block_t k0;
    block_t k1;
    block_t k2;
  } round_keys_t;

  localparam nibble_t SBOX [16] = '{
    4'd9, 4'd4, 4'd10, 4'd11, 4'd13, 4'd1, 4'd8, 4'd5,
    4'd6, 4'd2, 4'd0, 4'd3, 4'd12, 4'd14, 4'd15, 4'd7
  };

  localparam nibble_t SBOX_REV [16] = '{
    4'd10, 4'd5, 4'd9, 4'd11, 4'd1, 4'd7, 4'd8, 4'd15,
    4'd6, 4'd0, 4'd2, 4'd3, 4'd12, 4'd4, 4'd13, 4'd14
  };

  // Multiply by x modulo x^4 + x + 1.
  function automatic nibble_t gf_mul2(input nibble_t x);
    gf_mul2 = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic nibble_t gf_mul9(input nibble_t x);
    gf_mul9 = gf_mul2(gf_mul2(gf_mul2(x))) ^ x;
  endfunction

  // SubNib(RotNib(w)) on one byte.
  function automatic byte_t key_g(input byte_t w);
    key_g = {SBOX[w[3:0]], SBOX[w[7:4]]};
  endfunction

  function automatic block_t inv_shift_rows(input block_t s);
    inv_shift_rows = {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  function automatic block_t inv_sub_nibbles(input block_t s);
    inv_sub_nibbles = {SBOX_REV[s[15:12]], SBOX_REV[s[11:8]],
                       SBOX_REV[s[7:4]], SBOX_REV[s[3:0]]};
  endfunction

  function automatic block_t inv_mix_columns(input block_t s);
    inv_mix_columns = {gf_mul9(s[15:12]) ^ gf_mul2(s[11:8]),
                       gf_mul2(s[15:12]) ^ gf_mul9(s[11:8]),
                       gf_mul9(s[7:4])   ^ gf_mul2(s[3:0]),
                       gf_mul2(s[7:4])   ^ gf_mul9(s[3:0])};
  endfunction

endpackage

`default_nettype wire

### rtl/core/saes_key_expand.sv
// Key register and expansion of the cipher key into three round keys.
`timescale 1ns / 1ps
`default_nettype none

module saes_key_expand (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire saes_pkg::block_t      cfg_wr_data,
  output saes_pkg::round_keys_t      keys
);

  saes_pkg::block_t key_r;
  saes_pkg::block_t key_nxt;
  saes_pkg::byte_t  w0, w1, w2, w3, w4, w5;

  always_comb begin
    key_nxt = cfg_wr_en ? cfg_wr_data : key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  always_comb begin
    w0 = key_r[15:8];
    w1 = key_r[7:0];
    w2 = w0 ^ saes_pkg::RCON1 ^ saes_pkg::key_g(w1);
    w3 = w2 ^ w1;
    w4 = w2 ^ saes_pkg::RCON2 ^ saes_pkg::key_g(w3);
    w5 = w4 ^ w3;
    keys.k0 = {w0, w1};
    keys.k1 = {w2, w3};
    keys.k2 = {w4, w5};
  end

endmodule

`default_nettype wire

### rtl/core/saes_round_pipe.sv
// Three-stage decryption datapath with per-stage valid bits and backpressure.
`timescale 1ns / 1ps
`default_nettype none

module saes_round_pipe (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire saes_pkg::round_keys_t keys,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire saes_pkg::block_t      in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output saes_pkg::block_t           out_data
);

  logic             s1_valid_r, s2_valid_r, s3_valid_r;
  logic             s1_valid_nxt, s2_valid_nxt, s3_valid_nxt;
  logic             s1_ready, s2_ready, s3_ready;
  saes_pkg::block_t s1_data_r, s2_data_r, s3_data_r;
  saes_pkg::block_t s1_data_nxt, s2_data_nxt, s3_data_nxt;

  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    s1_data_nxt = saes_pkg::inv_sub_nibbles(saes_pkg::inv_shift_rows(in_data ^ keys.k2));
    s2_data_nxt = saes_pkg::inv_mix_columns(s1_data_r ^ keys.k1);
    s3_data_nxt = saes_pkg::inv_sub_nibbles(saes_pkg::inv_shift_rows(s2_data_r)) ^ keys.k0;

    s1_valid_nxt = s1_ready ? in_valid   : s1_valid_r;
    s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;
    s3_valid_nxt = s3_ready ? s2_valid_r : s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_data_r <= s1_data_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      s3_data_r <= s3_data_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = s3_data_r;

endmodule

`default_nettype wire

### rtl/core/saes_block_decrypt_core.sv
// Top level: S-AES 16-bit block decryption core.
//
// Usage:
//   Load the 16-bit key through cfg_wr_en / cfg_wr_data while no transaction
//   is in flight; the round keys are derived combinationally from the key register.
//   Ciphertext transactions enter on in_valid / in_ready, plaintext leaves on
//   out_valid / out_ready, one result per input, in order.
// Pipeline: an accepted input is registered once per stage, in order (first
//   inverse round, key add plus InvMixColumns, last round); out_valid rises
//   when the block reaches the last stage register.
// Throughput: one block per cycle unless out_ready stalls the pipeline; the
//   three stage registers set the pipeline depth and each stage takes a new
//   block while its successor moves on.
// Reset: rst_n low at a clock edge clears the key to zero and empties all
//   stages; in_ready is high after reset.
// Stall: when out_ready is low the final stage holds its block; upstream
//   stages keep filling bubbles and in_ready drops only once all three
//   stages hold data.
`timescale 1ns / 1ps
`default_nettype none

module saes_block_decrypt_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [15:0]  in_ciphertext,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [15:0]       out_plaintext
);

  saes_pkg::round_keys_t keys;

  saes_key_expand u_key_expand (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .keys        (keys)
  );

  saes_round_pipe u_round_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .keys      (keys),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_ciphertext),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_plaintext)
  );

`ifndef SYNTH
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_out_valid_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled full pipeline");
`endif

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for the S-AES decryption core: directed and random blocks vs. a local decryptor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned DRAIN_WAIT  = 6;
  localparam logic [7:0]  RCON_ONE    = 8'h80;
  localparam logic [7:0]  RCON_TWO    = 8'h30;

  localparam logic [3:0] SUB_FWD [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };
  localparam logic [3:0] SUB_INV [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] ct;
  } dir_row_t;

  localparam int unsigned DIR_COUNT = 22;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    {16'h0000, 16'h0000}, {16'h0000, 16'hFFFF}, {16'h0000, 16'h0001},
    {16'h0000, 16'h8000}, {16'h0000, 16'hF0F0}, {16'h0000, 16'h0F0F},
    // all-zero column into InvMixColumns
    {16'h0000, 16'h4F56}, {16'h0000, 16'h4F50}, {16'h0000, 16'h1234},
    {16'hFFFF, 16'h0000}, {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'h5A5A},
    {16'hFFFF, 16'hA5A5}, {16'hFFFF, 16'h8001},
    {16'h4AF5, 16'h24EC}, {16'h4AF5, 16'h14DC}, {16'h4AF5, 16'hD728},
    {16'hA73B, 16'h0738}, {16'hA73B, 16'h6F6B},
    {16'h0001, 16'hFFFF}, {16'h8000, 16'h0000}, {16'h8000, 16'hFFFF}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_ciphertext;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_plaintext;

  logic [15:0] key_model;
  logic [15:0] plaintext_due [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle;

  saes_block_decrypt_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ciphertext (in_ciphertext),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_plaintext (out_plaintext)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [3:0] nib_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = 4'h0;
    x   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rot_sub(input logic [7:0] w);
    return {SUB_FWD[w[3:0]], SUB_FWD[w[7:4]]};
  endfunction

  function automatic logic [15:0] swap_rows(input logic [15:0] s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  function automatic logic [15:0] unsub_block(input logic [15:0] s);
    return {SUB_INV[s[15:12]], SUB_INV[s[11:8]], SUB_INV[s[7:4]], SUB_INV[s[3:0]]};
  endfunction

  function automatic logic [15:0] decrypt_block(input logic [15:0] ct, input logic [15:0] key);
    logic [7:0]  w2;
    logic [7:0]  w3;
    logic [7:0]  w4;
    logic [7:0]  w5;
    logic [15:0] s;
    w2 = key[15:8] ^ RCON_ONE ^ rot_sub(key[7:0]);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ RCON_TWO ^ rot_sub(w3);
    w5 = w4 ^ w3;
    s  = ct ^ {w4, w5};
    s  = unsub_block(swap_rows(s)) ^ {w2, w3};
    s  = {nib_mul(4'h9, s[15:12]) ^ nib_mul(4'h2, s[11:8]),
          nib_mul(4'h2, s[15:12]) ^ nib_mul(4'h9, s[11:8]),
          nib_mul(4'h9, s[7:4])   ^ nib_mul(4'h2, s[3:0]),
          nib_mul(4'h2, s[7:4])   ^ nib_mul(4'h9, s[3:0])};
    return unsub_block(swap_rows(s)) ^ key;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (plaintext_due.size() == 0) begin
        $display("%0t: unexpected plaintext transaction, expected none, actual %h",
                 $time, out_plaintext);
        mismatches++;
      end else begin
        if (out_plaintext !== plaintext_due[0]) begin
          $display("%0t: plaintext mismatch, expected %h, actual %h",
                   $time, plaintext_due[0], out_plaintext);
          mismatches++;
        end
        void'(plaintext_due.pop_front());
      end
    end
    if (rst_n && in_valid && in_ready)
      plaintext_due.push_back(decrypt_block(in_ciphertext, key_model));
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // enter and leave at a falling edge
  task automatic send_block(input logic [15:0] ct);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_ciphertext <= ct;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (plaintext_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic load_key(input logic [15:0] key);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= key;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    key_model = key;
    repeat (2) @(negedge clk);
  endtask

  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [15:0] ct;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 16'h0000;
    in_valid      <= 1'b0;
    in_ciphertext <= 16'h0000;
    out_ready     <= 1'b0;
    key_model     = 16'h0000;
    no_idle       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].key != key_model) load_key(DIR_ROWS[i].key);
      send_block(DIR_ROWS[i].ct);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1)      load_key(16'hFFFF);
      else if (ph == 4) load_key(16'h0000);
      else              load_key(16'($urandom_range(0, 16'hFFFF)));
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) drain();
        if ($urandom_range(0, 9) == 0) ct = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else                           ct = 16'($urandom_range(0, 16'hFFFF));
        send_block(ct);
      end
    end

    drain();
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
